// ----- sv/imft_pkg.sv -----
// Shared types, constants and helpers for the masked IPv4 filter table.
// Used by imft_store, imft_match and ip_mask_filter_table_top.
package imft_pkg;

	localparam int MAX_FILTERS = 1024;
	localparam int IDX_W = $clog2(MAX_FILTERS);
	localparam int CNT_W = $clog2(MAX_FILTERS + 1);

	localparam logic [31:0] FREE_SLOT = 32'hFFFF_FFFF;

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_ADD    = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_BAD       = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] address;
		logic        address_valid;
	} in_t;

	typedef struct packed {
		logic       admit;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic [31:0] mask;
		logic [31:0] cmp;
	} entry_t;

	function automatic logic [31:0] octet_mask(input logic [31:0] addr);
		logic [31:0] m;
		m = '0;
		for (int n = 0; n < 4; n++) begin
			if (addr[8*n +: 8] != 8'd0) begin
				m[8*n +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ----- sv/imft_store.sv -----
// Filter entry memory: one write port, one registered read port.
// Depends on imft_pkg for depth and entry type.
module imft_store (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [imft_pkg::IDX_W-1:0] wr_addr,
	input  imft_pkg::entry_t      wr_data,
	input  logic                  rd_en,
	input  logic [imft_pkg::IDX_W-1:0] rd_addr,
	output imft_pkg::entry_t      rd_data
);
	import imft_pkg::*;

	entry_t mem_q [MAX_FILTERS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/imft_match.sv -----
// Shared entry compare unit: one entry against the current operation per cycle.
// Depends on imft_pkg for function codes and entry type.
module imft_match (
	input  logic [1:0]        func,
	input  logic [31:0]       address,
	input  logic [31:0]       key_mask,
	input  imft_pkg::entry_t  entry,
	output logic              hit
);
	import imft_pkg::*;

	always_comb begin
		case (func)
			FUNC_LOOKUP: hit = (address & entry.mask) == entry.cmp;
			FUNC_ADD:    hit = entry.cmp == FREE_SLOT;
			FUNC_REMOVE: hit = (entry.mask == key_mask) && (entry.cmp == address);
			default:     hit = 1'b0;
		endcase
	end

endmodule

// ----- sv/ip_mask_filter_table_top.sv -----
// Masked IPv4 filter table: sequencer that scans and shifts the entry memory.
// Depends on imft_pkg, imft_store and imft_match.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------
//  command  | start / busy            | item   (imft_pkg::in_t)
//  result   | result_valid (strobe)   | result (imft_pkg::out_t)
//  config   | cfg_valid / cfg_ready   | cfg_data (ban mode)
//
// Lookup and add keep busy high while they scan the table, one memory read per entry
// through the registered read port; the strobe rises in the cycle in which busy falls.
// Remove keeps busy high through the scan and, on a match, while later entries shift down.
// Bad remove and unused codes keep busy low and answer in the next cycle.
// After reset all entries of the memory are cleared with busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module ip_mask_filter_table_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  imft_pkg::in_t    item,
	output logic             result_valid,
	output imft_pkg::out_t   result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);
	import imft_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_SHIFT = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       op_q;
	logic [31:0]      addr_q;
	logic [31:0]      key_q;
	logic             valid_q;
	logic             ban_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] chk_idx_q;
	logic             chk_vld_q;
	logic             done_q;
	out_t             res_q;

	logic [CNT_W-1:0] lim;
	logic             issue;
	logic             cmp_hit;
	logic             append;
	logic             hit;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	entry_t           rd_data;
	logic [CNT_W-1:0] shift_dst;

	imft_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	imft_match u_match (
		.func     (op_q),
		.address  (addr_q),
		.key_mask (key_q),
		.entry    (rd_data),
		.hit      (cmp_hit)
	);

	always_comb begin
		case (op_q)
			FUNC_ADD: lim = (count_q == CNT_W'(MAX_FILTERS)) ? count_q : count_q + 1'b1;
			default:  lim = count_q;
		endcase
	end

	assign append = (op_q == FUNC_ADD) && (chk_idx_q == count_q);
	assign hit    = chk_vld_q && (cmp_hit || append);
	assign shift_dst = chk_idx_q - 1'b1;

	always_comb begin
		case (state_q)
			ST_SCAN:  issue = rd_idx_q < lim;
			ST_SHIFT: issue = rd_idx_q < count_q;
			default:  issue = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_idx_q[IDX_W-1:0];
		wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = rd_idx_q[IDX_W-1:0];
			end
			ST_SCAN: begin
				if (hit && op_q == FUNC_ADD) begin
					wr_en = 1'b1;
					if (valid_q) begin
						wr_data.mask = key_q;
						wr_data.cmp  = addr_q;
					end else begin
						wr_data.mask = rd_data.mask;
						wr_data.cmp  = FREE_SLOT;
					end
				end
			end
			ST_SHIFT: begin
				wr_en   = chk_vld_q;
				wr_addr = shift_dst[IDX_W-1:0];
				wr_data = rd_data;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			rd_idx_q  <= '0;
			chk_vld_q <= 1'b0;
			count_q   <= '0;
			ban_q     <= 1'b1;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				ban_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == CNT_W'(MAX_FILTERS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q      <= item.func;
						addr_q    <= item.address;
						key_q     <= octet_mask(item.address);
						valid_q   <= item.address_valid;
						rd_idx_q  <= '0;
						chk_vld_q <= 1'b0;
						case (item.func)
							FUNC_LOOKUP, FUNC_ADD: state_q <= ST_SCAN;
							FUNC_REMOVE: begin
								if (item.address_valid) begin
									state_q <= ST_SCAN;
								end else begin
									done_q <= 1'b1;
									res_q  <= '{admit: 1'b0, status: STAT_BAD};
								end
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '{admit: 1'b0, status: STAT_DONE};
							end
						endcase
					end
				end
				ST_SCAN: begin
					chk_vld_q <= issue;
					chk_idx_q <= rd_idx_q;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (hit) begin
						case (op_q)
							FUNC_LOOKUP: begin
								done_q  <= 1'b1;
								res_q   <= '{admit: ~ban_q, status: STAT_DONE};
								state_q <= ST_IDLE;
							end
							FUNC_ADD: begin
								if (append) begin
									count_q <= count_q + 1'b1;
								end
								done_q  <= 1'b1;
								res_q   <= '{admit: 1'b0,
									status: valid_q ? STAT_DONE : STAT_BAD};
								state_q <= ST_IDLE;
							end
							default: begin
								rd_idx_q  <= chk_idx_q + 1'b1;
								chk_vld_q <= 1'b0;
								state_q   <= ST_SHIFT;
							end
						endcase
					end else if (!chk_vld_q && !issue) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						case (op_q)
							FUNC_LOOKUP: res_q <= '{admit: ban_q, status: STAT_DONE};
							FUNC_ADD:    res_q <= '{admit: 1'b0, status: STAT_FULL};
							default:     res_q <= '{admit: 1'b0, status: STAT_NOT_FOUND};
						endcase
					end
				end
				ST_SHIFT: begin
					chk_vld_q <= issue;
					chk_idx_q <= rd_idx_q;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (!issue && !chk_vld_q) begin
						count_q <= count_q - 1'b1;
						done_q  <= 1'b1;
						res_q   <= '{admit: 1'b0, status: STAT_DONE};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign cfg_ready    = 1'b1;
	assign result_valid = done_q;
	assign result       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FILTERS))
		else $error("entry count above capacity");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == ST_IDLE)
		else $error("result strobe while sequencer active");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> result_valid)
		else $error("entry count changed without a completed transaction");

	a_lookup_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && op_q == FUNC_LOOKUP) |-> !wr_en)
		else $error("memory written during lookup");

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.func == FUNC_LOOKUP) |=> state_q == ST_SCAN)
		else $error("lookup transaction did not enter scan");

endmodule

// ----- tb/sv/filter_table_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the masked IPv4 filter table: mirrors the mask/compare tables and ban mode,
// predicts one result per accepted command and checks the result strobe against it.
// Depends on imft_pkg.
module filter_table_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  imft_pkg::in_t  item,
	input  logic           result_valid,
	input  imft_pkg::out_t result,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic           cfg_data,
	output int             fails,
	output int             pending
);
	import imft_pkg::*;

	logic [31:0] masks [MAX_FILTERS];
	logic [31:0] cmps  [MAX_FILTERS];
	int          entries;
	logic        ban;
	int          nerr = 0;
	out_t        outcomes [$];

	function automatic logic [31:0] mask_for(input logic [31:0] a);
		logic [31:0] m;
		for (int b = 0; b < 4; b++) begin
			m[8*b +: 8] = {8{|a[8*b +: 8]}};
		end
		return m;
	endfunction

	function automatic logic table_hit(input logic [31:0] a);
		for (int i = 0; i < entries; i++) begin
			if ((a & masks[i]) == cmps[i]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [1:0] add_filter(input logic [31:0] a, input logic ok);
		int slot;
		slot = 0;
		while (slot < entries && cmps[slot] != FREE_SLOT) begin
			slot++;
		end
		if (slot == entries) begin
			if (entries >= MAX_FILTERS) begin
				return STAT_FULL;
			end
			entries++;
		end
		// bad text still claims the slot, but only as a free one
		if (!ok) begin
			cmps[slot] = FREE_SLOT;
			return STAT_BAD;
		end
		masks[slot] = mask_for(a);
		cmps[slot]  = a;
		return STAT_DONE;
	endfunction

	function automatic logic [1:0] remove_filter(input logic [31:0] a, input logic ok);
		logic [31:0] m;
		if (!ok) begin
			return STAT_BAD;
		end
		m = mask_for(a);
		for (int i = 0; i < entries; i++) begin
			if (masks[i] == m && cmps[i] == a) begin
				for (int j = i + 1; j < entries; j++) begin
					masks[j-1] = masks[j];
					cmps[j-1]  = cmps[j];
				end
				entries--;
				return STAT_DONE;
			end
		end
		return STAT_NOT_FOUND;
	endfunction

	function automatic out_t filter_outcome(input in_t it);
		out_t r;
		r = '0;
		case (it.func)
			FUNC_LOOKUP: r.admit  = table_hit(it.address) ? !ban : ban;
			FUNC_ADD:    r.status = add_filter(it.address, it.address_valid);
			FUNC_REMOVE: r.status = remove_filter(it.address, it.address_valid);
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_FILTERS; i++) begin
				masks[i] = '0;
				cmps[i]  = '0;
			end
			entries = 0;
			ban = 1'b1;
			outcomes.delete();
			pending <= 0;
			fails <= nerr;
		end else begin
			if (result_valid) begin
				if (outcomes.size() == 0) begin
					nerr++;
					$display("%0t UNEXPECTED result: admit %0b status %0d", $time,
						result.admit, result.status);
				end else begin
					want = outcomes.pop_front();
					if (result.admit !== want.admit || result.status !== want.status) begin
						nerr++;
						$display("%0t MISMATCH: expected admit %0b status %0d, got admit %0b status %0d",
							$time, want.admit, want.status, result.admit, result.status);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				ban = cfg_data;
			end
			// one result per command transaction
			if (start && !busy) begin
				outcomes.push_back(filter_outcome(item));
			end
			pending <= outcomes.size();
			fails <= nerr;
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for ip_mask_filter_table_top: clock, reset, command and ban-mode stimulus
// and the final verdict. Depends on imft_pkg, filter_table_checker and the table RTL.
module tb;
	import imft_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 580;
	localparam int PHASES = 4;
	localparam int LIMIT = 3 * (RANDOM_ITEMS + MAX_FILTERS + 64) * (2 * MAX_FILTERS + 16)
		+ 4 * MAX_FILTERS;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         item;
	logic        result_valid;
	out_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	int          fails;
	int          pending;
	int          cycles = 0;
	int          gap_pct = 0;
	logic [31:0] pool [$];
	logic [31:0] fill [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ip_mask_filter_table_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	filter_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// start stays high into the next command unless a gap is drawn
	task automatic issue_cmd(input logic [1:0] func, input logic [31:0] addr, input logic ok);
		in_t it;
		it.func = func;
		it.address = addr;
		it.address_valid = ok;
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_ban(input logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_octets();
		logic [31:0] a;
		for (int n = 0; n < 4; n++) begin
			case ($urandom_range(0, 5))
				0, 1: a[8*n +: 8] = 8'd0;
				2: a[8*n +: 8] = 8'hFF;
				default: a[8*n +: 8] = 8'($urandom_range(1, 255));
			endcase
		end
		return a;
	endfunction

	initial begin
		int          sel;
		int          add_pct;
		int          idx;
		logic [31:0] a;
		logic        ok;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 20;
		issue_cmd(FUNC_LOOKUP, 32'h0000_0000, 1'b1);
		issue_cmd(FUNC_ADD, 32'h0000_000A, 1'b1);
		issue_cmd(FUNC_LOOKUP, 32'h0505_050A, 1'b0);
		issue_cmd(FUNC_LOOKUP, 32'h0000_000B, 1'b1);
		issue_cmd(FUNC_ADD, 32'h1234_5678, 1'b0);
		issue_cmd(FUNC_ADD, 32'h0403_0201, 1'b1);
		issue_cmd(FUNC_ADD, FREE_SLOT, 1'b1);
		issue_cmd(FUNC_LOOKUP, FREE_SLOT, 1'b1);
		issue_cmd(FUNC_ADD, 32'h00C0_00A8, 1'b1);
		issue_cmd(FUNC_REMOVE, 32'h0000_000A, 1'b0);
		issue_cmd(FUNC_REMOVE, 32'h0000_0B00, 1'b1);
		issue_cmd(FUNC_REMOVE, 32'h0000_000A, 1'b1);
		issue_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1);
		issue_cmd(FUNC_ADD, 32'h0000_0000, 1'b1);
		issue_cmd(FUNC_LOOKUP, 32'hDEAD_BEEF, 1'b0);
		issue_cmd(FUNC_REMOVE, 32'h0000_0000, 1'b1);
		issue_cmd(FUNC_ADD, FREE_SLOT, 1'b1);
		issue_cmd(FUNC_REMOVE, FREE_SLOT, 1'b1);
		issue_cmd(FUNC_LOOKUP, 32'h4403_0201, 1'b1);
		write_ban(1'b0);
		issue_cmd(FUNC_LOOKUP, 32'h0403_0201, 1'b1);
		issue_cmd(FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1);
		issue_cmd(FUNC_LOOKUP, 32'h77C0_99A8, 1'b0);
		pool.push_back(32'h0403_0201);
		pool.push_back(32'h00C0_00A8);

		for (int p = 0; p < PHASES; p++) begin
			write_ban(p % 2 == 0);
			case (p)
				0: gap_pct = 25;
				1: gap_pct = 0;
				2: gap_pct = 50;
				default: gap_pct = 15;
			endcase
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				sel = $urandom_range(0, 99);
				ok = ($urandom_range(0, 9) != 0);
				a = pick_octets();
				add_pct = (pool.size() < 12) ? 35 : ((pool.size() > 40) ? 15 : 27);
				if ($urandom_range(0, 39) == 0) begin
					drain();
				end
				if (sel < 38) begin
					if (pool.size() != 0 && sel < 26) begin
						a = pool[$urandom_range(0, pool.size() - 1)];
						// wildcard octets of a stored filter still hit
						if (sel < 18) begin
							for (int n = 0; n < 4; n++) begin
								if (a[8*n +: 8] == 8'd0) begin
									a[8*n +: 8] = 8'($urandom_range(0, 255));
								end
							end
						end
					end
					issue_cmd(FUNC_LOOKUP, a, ok);
				end else if (sel < 38 + add_pct) begin
					if ($urandom_range(0, 49) == 0) begin
						a = FREE_SLOT;
					end
					if (ok && a != FREE_SLOT) begin
						pool.push_back(a);
					end
					issue_cmd(FUNC_ADD, a, ok);
				end else if (sel < 41 + add_pct) begin
					issue_cmd(FUNC_UNUSED, a, ok);
				end else begin
					if (pool.size() != 0 && $urandom_range(0, 3) != 0) begin
						idx = $urandom_range(0, pool.size() - 1);
						a = pool[idx];
						if (ok) begin
							pool.delete(idx);
						end
					end
					issue_cmd(FUNC_REMOVE, a, ok);
				end
			end
		end

		// fill to capacity, then work at the full boundary
		write_ban(1'b1);
		gap_pct = 0;
		for (int k = 0; k < MAX_FILTERS + 4; k++) begin
			do a = pick_octets(); while (a == FREE_SLOT);
			fill.push_back(a);
			issue_cmd(FUNC_ADD, a, 1'b1);
		end
		issue_cmd(FUNC_ADD, pick_octets(), 1'b0);
		issue_cmd(FUNC_LOOKUP, fill[0], 1'b1);
		issue_cmd(FUNC_REMOVE, fill[1], 1'b1);
		issue_cmd(FUNC_ADD, FREE_SLOT, 1'b1);
		issue_cmd(FUNC_ADD, fill[2], 1'b0);
		issue_cmd(FUNC_ADD, fill[3], 1'b1);
		issue_cmd(FUNC_ADD, fill[4], 1'b1);
		issue_cmd(FUNC_REMOVE, fill[MAX_FILTERS / 2], 1'b1);
		issue_cmd(FUNC_LOOKUP, pick_octets(), 1'b1);

		drain();
		repeat (2 * MAX_FILTERS + 8) @(posedge clk);
		if (fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- ip_mask_filter_table_top.f -----
sv/imft_pkg.sv
sv/imft_store.sv
sv/imft_match.sv
sv/ip_mask_filter_table_top.sv
tb/sv/filter_table_checker.sv
tb/sv/tb.sv
